FILE: rtl/palt_pkg.sv
// Package for the peer address list table.
// Holds sizes, operation and status codes and the structs shared by the
// controller, the address memory and the top level. No dependencies.
package palt_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = 4;   // address of one memory entry
	localparam int CNT_W   = 5;   // entry count, 0 .. ENTRIES
	localparam int ADDR_W  = 48;
	localparam int NLEN_W  = 10;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 3'd0,
		OP_ADD   = 3'd1,
		OP_DEL   = 3'd2,
		OP_GET   = 3'd3,
		OP_UP    = 3'd4,
		OP_DOWN  = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NAMEEMPTY = 3'd2,
		ST_DUP       = 3'd3,
		ST_NOTFOUND  = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [ADDR_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] sel;
		logic [CNT_W-1:0]  count;
		logic [IDX_W-1:0]  cursor;
	} result_t;

endpackage

FILE: rtl/palt_mem.sv
// Address store of the peer address list table: one write port and one
// read port with registered read data. Depends on palt_pkg.
module palt_mem
	import palt_pkg::*;
(
	input  logic              clk,
	input  mem_req_t          req,
	output logic [ADDR_W-1:0] rdata
);

	logic [ADDR_W-1:0] store_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			store_q[req.waddr] <= req.wdata;
		end
		rdata <= store_q[req.raddr];
	end

endmodule

FILE: rtl/palt_ctrl.sv
// Sequencer of the peer address list table: decodes one item, walks the
// store one entry at a time with a single 48-bit comparator, closes gaps
// on delete and builds the result. Depends on palt_pkg.
module palt_ctrl
	import palt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   in_op,
	input  logic [ADDR_W-1:0] in_addr,
	input  logic [NLEN_W-1:0] in_nlen,
	input  logic              res_free,
	output logic              res_valid,
	output result_t           res,
	output mem_req_t          mem_req,
	input  logic [ADDR_W-1:0] mem_rdata
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SRD, S_SCMP, S_APPEND,
		S_MRD, S_MWR, S_DEL_END, S_GRD, S_GDAT, S_FIN
	} state_t;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [NLEN_W-1:0] nlen_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  cursor_q;
	logic [CNT_W-1:0]  idx_q;
	logic [IDX_W-1:0]  hit_q;
	status_t           status_q;
	logic [ADDR_W-1:0] sel_q;

	logic [CNT_W-1:0]  idx_nxt;
	logic [CNT_W-1:0]  cur_nxt;
	logic              match;

	assign idx_nxt = idx_q + CNT_W'(1);
	assign cur_nxt = CNT_W'(cursor_q) + CNT_W'(1);
	// shared comparator
	assign match   = (mem_rdata == addr_q);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN) && res_free;
	assign res       = '{status: status_q, sel: sel_q, count: count_q, cursor: cursor_q};

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = idx_q[IDX_W-1:0];
		mem_req.wdata = addr_q;
		mem_req.raddr = idx_q[IDX_W-1:0];
		case (state_q)
			S_APPEND: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = count_q[IDX_W-1:0];
			end
			S_MWR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = IDX_W'(idx_q - CNT_W'(1));
				mem_req.wdata = mem_rdata;
			end
			S_GRD: begin
				mem_req.raddr = cursor_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
			op_q     <= '0;
			addr_q   <= '0;
			nlen_q   <= '0;
			idx_q    <= '0;
			hit_q    <= '0;
			status_q <= ST_OK;
			sel_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= in_op;
						addr_q   <= in_addr;
						nlen_q   <= in_nlen;
						idx_q    <= '0;
						status_q <= ST_OK;
						sel_q    <= '0;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FIN;
					case (op_q)
						OP_CLEAR: begin
							count_q  <= '0;
							cursor_q <= '0;
						end
						OP_ADD: begin
							if (count_q >= CNT_W'(ENTRIES)) begin
								status_q <= ST_FULL;
							end else if (nlen_q == NLEN_W'(1)) begin
								status_q <= ST_NAMEEMPTY;
							end else if (count_q == '0) begin
								state_q <= S_APPEND;
							end else begin
								state_q <= S_SRD;
							end
						end
						OP_DEL: begin
							if (count_q == '0) begin
								status_q <= ST_NOTFOUND;
							end else begin
								state_q <= S_SRD;
							end
						end
						OP_GET: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								state_q <= S_GRD;
							end
						end
						OP_UP: begin
							if (cursor_q != '0) begin
								cursor_q <= cursor_q - IDX_W'(1);
							end
						end
						OP_DOWN: begin
							if (cur_nxt < count_q) begin
								cursor_q <= cursor_q + IDX_W'(1);
							end
						end
						default: begin
						end
					endcase
				end
				S_SRD: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					idx_q <= idx_nxt;
					if (match) begin
						if (op_q == OP_ADD) begin
							status_q <= ST_DUP;
							state_q  <= S_FIN;
						end else begin
							hit_q   <= idx_q[IDX_W-1:0];
							state_q <= (idx_nxt < count_q) ? S_MRD : S_DEL_END;
						end
					end else if (idx_nxt < count_q) begin
						state_q <= S_SRD;
					end else if (op_q == OP_ADD) begin
						state_q <= S_APPEND;
					end else begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_FIN;
					end
				end
				S_APPEND: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_FIN;
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					idx_q   <= idx_nxt;
					state_q <= (idx_nxt < count_q) ? S_MRD : S_DEL_END;
				end
				S_DEL_END: begin
					if (cursor_q == hit_q) begin
						cursor_q <= '0;
					end else if (cursor_q > hit_q) begin
						cursor_q <= cursor_q - IDX_W'(1);
					end
					count_q <= count_q - CNT_W'(1);
					state_q <= S_FIN;
				end
				S_GRD: begin
					state_q <= S_GDAT;
				end
				S_GDAT: begin
					sel_q   <= mem_rdata;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/peer_address_list_table.sv
// Peer address list table, top level. One item is handled at a time:
// the sequencer walks the store one entry at a time through its single
// read port and comparator for add and delete, and the next item is
// taken only once the result is registered. Reset (arst_n low)
// empties the list and zeroes the cursor; store contents stay undefined.
module peer_address_list_table
	import palt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [47:0] peer_address, [57:48] name_length, rest zero
	input  logic [7:0]  s_tuser,   // [2:0] operation, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [47:0] selected_address, [52:48] entry_count,
	                               // [56:53] cursor_index, rest zero
	output logic [7:0]  m_tuser    // [2:0] status, rest zero
);

	mem_req_t          mem_req;
	logic [ADDR_W-1:0] mem_rdata;
	logic              res_valid;
	logic              res_free;
	result_t           res;

	// Output register: holds a finished result while the sequencer goes idle
	logic              m_valid_q;
	result_t           m_res_q;

	assign res_free = !m_valid_q || m_tready;

	palt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser[OP_W-1:0]),
		.in_addr   (s_tdata[ADDR_W-1:0]),
		.in_nlen   (s_tdata[ADDR_W+NLEN_W-1:ADDR_W]),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	palt_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// Load a new result when the slot is free; drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_res_q.cursor, m_res_q.count, m_res_q.sel};
	assign m_tuser  = {5'd0, m_res_q.status};

endmodule

FILE: tb/peer_list_check.sv
// Checker for the peer address list table: watches both stream channels,
// keeps its own copy of the list, predicts each result and compares it.
// Depends on palt_pkg for sizes, codes and the result struct.
module peer_list_check
	import palt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [7:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [7:0]  m_tuser,
	output int          failures,
	output int          outstanding,
	output int          results_seen
);

	logic [ADDR_W-1:0] peer_store [ENTRIES];
	int                peer_count = 0;
	int                sel_cursor = 0;
	result_t           pending_results [$];
	int                fail_total = 0;
	int                seen_total = 0;

	// Apply one operation to the list copy and return the result it gives.
	function automatic result_t apply_peer_op(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
	                                          logic [NLEN_W-1:0] nlen);
		result_t r;
		int      hit;
		r.status = ST_OK;
		r.sel    = '0;
		hit      = -1;
		for (int i = 0; i < peer_count; i++) begin
			if (hit < 0 && peer_store[i] == addr)
				hit = i;
		end
		case (op)
			OP_CLEAR: begin
				peer_count = 0;
				sel_cursor = 0;
			end
			OP_ADD: begin
				if (peer_count >= ENTRIES)
					r.status = ST_FULL;
				else if (nlen == NLEN_W'(1))
					r.status = ST_NAMEEMPTY;
				else if (hit >= 0)
					r.status = ST_DUP;
				else begin
					peer_store[peer_count] = addr;
					peer_count++;
				end
			end
			OP_DEL: begin
				if (hit < 0)
					r.status = ST_NOTFOUND;
				else begin
					for (int j = hit + 1; j < peer_count; j++)
						peer_store[j-1] = peer_store[j];
					if (sel_cursor == hit)
						sel_cursor = 0;
					else if (sel_cursor > hit)
						sel_cursor--;
					peer_count--;
				end
			end
			OP_GET: begin
				if (peer_count == 0)
					r.status = ST_EMPTY;
				else
					r.sel = peer_store[sel_cursor % ENTRIES];
			end
			OP_UP: begin
				if (sel_cursor > 0)
					sel_cursor--;
			end
			OP_DOWN: begin
				if (peer_count > 0 && sel_cursor + 1 < peer_count)
					sel_cursor++;
			end
			default: ;
		endcase
		r.count  = peer_count[CNT_W-1:0];
		r.cursor = sel_cursor[IDX_W-1:0];
		return r;
	endfunction

	function automatic void report_field(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		logic    bad;
		if (!arst_n) begin
			peer_count = 0;
			sel_cursor = 0;
			pending_results.delete();
			outstanding  <= 0;
			failures     <= fail_total;
			results_seen <= seen_total;
		end else begin
			// a result leaving at this edge belongs to an item taken earlier
			if (m_tvalid && m_tready) begin
				seen_total++;
				got.status = status_t'(m_tuser[STAT_W-1:0]);
				got.sel    = m_tdata[ADDR_W-1:0];
				got.count  = m_tdata[ADDR_W+CNT_W-1:ADDR_W];
				got.cursor = m_tdata[ADDR_W+CNT_W+IDX_W-1:ADDR_W+CNT_W];
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, got %h", $time,
					         {m_tuser, m_tdata});
					fail_total++;
				end else begin
					want = pending_results.pop_front();
					bad  = 1'b0;
					if (got.status !== want.status) begin
						report_field("status", 64'(want.status), 64'(got.status));
						bad = 1'b1;
					end
					if (got.sel !== want.sel) begin
						report_field("selected_address", 64'(want.sel), 64'(got.sel));
						bad = 1'b1;
					end
					if (got.count !== want.count) begin
						report_field("entry_count", 64'(want.count), 64'(got.count));
						bad = 1'b1;
					end
					if (got.cursor !== want.cursor) begin
						report_field("cursor_index", 64'(want.cursor), 64'(got.cursor));
						bad = 1'b1;
					end
					if (bad)
						fail_total++;
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_peer_op(s_tuser[OP_W-1:0],
				                                        s_tdata[ADDR_W-1:0],
				                                        s_tdata[ADDR_W+NLEN_W-1:ADDR_W]));
			outstanding  <= pending_results.size();
			failures     <= fail_total;
			results_seen <= seen_total;
		end
	end

endmodule

FILE: tb/testbench.sv
// Top of the peer address list table testbench: clock, reset, stimulus
// and verdict. Depends on palt_pkg, the block and peer_list_check.
module testbench;
	import palt_pkg::*;

	// Operation codes the block must ignore while still answering
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 800;
	localparam int QUIET_TAIL   = 120;   // last items run with no idling
	localparam int SETTLE       = 2 * ENTRIES + 8;
	localparam int POOL_N       = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [7:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [7:0]  m_tuser;

	int failures;
	int outstanding;
	int results_seen;

	logic              idle_on = 1'b0;
	int                stall_left = 0;
	int                op_hits [8];
	logic [ADDR_W-1:0] addr_pool [POOL_N];

	peer_address_list_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	peer_list_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.failures     (failures),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver: hold ready low in random bursts while idling is on
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one item, after an optional idle burst, and hold it until taken.
	// Valid stays high on return so that back-to-back items need no gap.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
	                         input logic [NLEN_W-1:0] nlen);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {5'b0, op};
		s_tdata  <= {6'b0, nlen, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		op_hits[op]++;
	endtask

	// Drop valid and hold off until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Mostly addresses from a small pool so that duplicates and hits occur
	function automatic logic [ADDR_W-1:0] pick_addr();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			return raw[ADDR_W-1:0];
		return addr_pool[$urandom_range(0, POOL_N - 1)];
	endfunction

	// A name length of one is the empty-name case; give it a fair share
	function automatic logic [NLEN_W-1:0] pick_nlen();
		if ($urandom_range(0, 9) == 0)
			return 10'd1;
		return NLEN_W'($urandom_range(0, 1023));
	endfunction

	// One random item; add_pct sets how hard the list is pushed towards full
	task automatic random_item(input int add_pct);
		logic [OP_W-1:0] op;
		int              r;
		r = $urandom_range(0, 99);
		if (r < add_pct)
			op = OP_ADD;
		else begin
			r = $urandom_range(0, 99);
			if (r < 25)      op = OP_DEL;
			else if (r < 45) op = OP_GET;
			else if (r < 62) op = OP_UP;
			else if (r < 87) op = OP_DOWN;
			else if (r < 91) op = OP_SPARE_LO;
			else if (r < 95) op = OP_SPARE_HI;
			else             op = OP_CLEAR;
		end
		send_item(op, pick_addr(), pick_nlen());
	endtask

	initial begin
		logic [ADDR_W-1:0] peer_a;
		logic [63:0]       raw_addr;
		int                random_sent;
		int                session_len;
		int                add_pct;
		random_sent = 0;
		foreach (op_hits[i]) op_hits[i] = 0;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++) begin
			raw_addr     = {$urandom, $urandom};
			addr_pool[i] = raw_addr[ADDR_W-1:0];
		end
		peer_a = addr_pool[2];

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list corners, add checks, cursor moves, deletes
		send_item(OP_GET, '0, '0);                 // get on empty list
		send_item(OP_UP, '0, '0);
		send_item(OP_DOWN, '0, '0);                // down on empty list
		send_item(OP_DEL, peer_a, '0);             // delete of absent address
		send_item(OP_ADD, peer_a, 10'd1);          // empty name
		send_item(OP_ADD, '0, 10'd0);              // all-zero address
		send_item(OP_ADD, '1, 10'd1023);           // all-ones address, longest name
		send_item(OP_ADD, peer_a, 10'd2);
		send_item(OP_ADD, '0, 10'd5);              // duplicate
		send_item(OP_DOWN, '0, '0);
		send_item(OP_DOWN, '0, '0);
		send_item(OP_DOWN, '0, '0);                // already at the last entry
		send_item(OP_GET, '0, '0);
		send_item(OP_DEL, '0, '0);                 // removal below the cursor
		send_item(OP_GET, '0, '0);
		send_item(OP_DEL, peer_a, '0);             // removal under the cursor
		send_item(OP_UP, '0, '0);                  // up at zero
		send_item(OP_SPARE_LO, '1, '1);
		send_item(OP_SPARE_HI, '1, '1);
		send_item(OP_DEL, peer_a, '0);
		send_item(OP_GET, '1, '1);
		send_item(OP_CLEAR, '1, '1);
		send_item(OP_GET, '0, '0);
		drain_results();

		// Random sessions: each starts from a clear list, some lean on adds
		// hard enough to reach a full list and its rejections
		while (random_sent < RANDOM_ITEMS) begin
			session_len = $urandom_range(20, 80);
			add_pct     = ($urandom_range(0, 2) == 0) ? 75 : 40;
			idle_on     = $urandom_range(0, 3) != 0;
			if (random_sent >= RANDOM_ITEMS - QUIET_TAIL)
				idle_on = 1'b0;
			send_item(OP_CLEAR, pick_addr(), pick_nlen());
			random_sent++;
			for (int i = 0; i < session_len && random_sent < RANDOM_ITEMS; i++) begin
				if (random_sent >= RANDOM_ITEMS - QUIET_TAIL)
					idle_on = 1'b0;
				random_item(add_pct);
				random_sent++;
			end
			if ($urandom_range(0, 2) == 0)
				drain_results();
		end

		idle_on = 1'b0;
		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d items: clear %0d, add %0d, delete %0d, get %0d, up %0d, down %0d,",
		         op_hits.sum(), op_hits[OP_CLEAR], op_hits[OP_ADD], op_hits[OP_DEL],
		         op_hits[OP_GET], op_hits[OP_UP], op_hits[OP_DOWN]);
		$display("ignored codes %0d; %0d results checked, %0d failing.",
		         op_hits[OP_SPARE_LO] + op_hits[OP_SPARE_HI], results_seen, failures);
		if (failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Watchdog well beyond the slowest correct run
	initial begin
		#(12 * 400000);
		$display("Timeout with %0d results still outstanding", outstanding);
		$display("testbench: FAIL");
		$finish;
	end

endmodule
